// ===== hdl/assert_macros.svh =====
// Shared assertion macros for the sequencer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> b holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: a |-> b");

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: a |=> b");

`endif

// ===== hdl/lcdseq_pkg.sv =====
`default_nettype none

package lcdseq_pkg;

    typedef enum logic [2:0]
    {
        OP_WR_CMD    = 3'd0,
        OP_WR_DATA   = 3'd1,
        OP_INIT      = 3'd2,
        OP_SET_POS   = 3'd3,
        OP_SET_GLYPH = 3'd4
    } opcode_t;

    localparam logic [7:0] CMD_HOME        = 8'h02;
    localparam logic [7:0] CMD_FUNC_8BIT   = 8'h38;
    localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] DDRAM_LINE0     = 8'h80;
    localparam logic [7:0] DDRAM_LINE1     = 8'hC0;
    localparam logic [7:0] CGRAM_BASE      = 8'h40;

    localparam logic [5:0] POWER_UP_WAIT_MS = 6'd50;

    // init step index: 0 is the 4-bit-only home command, 3 is clear
    localparam logic [2:0] INIT_FIRST_4BIT = 3'd0;
    localparam logic [2:0] INIT_FIRST_8BIT = 3'd1;
    localparam logic [2:0] INIT_CLEAR_IDX  = 3'd3;
    localparam logic [2:0] INIT_LAST_IDX   = 3'd4;
    localparam logic [2:0] INIT_DONE_IDX   = 3'd5;

    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_SHORT = 2'd1;
    localparam logic [1:0] EXTRA_CLEAR = 2'd2;

    typedef struct packed
    {
        logic       load;        // start a transfer
        logic       wait_state;  // power-up wait instead of a byte transfer
        logic       rs;
        logic [7:0] data;
        logic [1:0] extra;       // settling ms added to the final hold
        logic       final_xfer;  // last transfer of the request
    } dp_cmd_t;

    typedef struct packed
    {
        logic idle;
    } dp_status_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx, input logic mode4);
        logic [7:0] result;
        unique case (idx)
            3'd0:    result = CMD_HOME;
            3'd1:    result = mode4 ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
            3'd2:    result = CMD_DISPLAY_ON;
            3'd3:    result = CMD_CLEAR;
            3'd4:    result = CMD_ENTRY_MODE;
            default: result = CMD_ENTRY_MODE;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/char_lcd_interface_sequencer_core.sv =====
// Character LCD sequencer: each request on the s_ stream (write command, write data,
// init, set cursor position, set glyph address) becomes a run of timed pin states on
// the m_ stream, each giving enable, data bus and a hold time in ms, with register
// select on m_tuser and m_tlast on the final state of the request. Once a request
// is taken, the block produces one pin state per cycle within a byte transfer while
// the output register is free or being taken, with a controller turnaround after
// each byte transfer and after the power-up wait. Requests that give no pin states
// are taken without leaving the idle state. The next request is taken only after
// the datapath has gone idle behind the last pin state of the current one and the
// controller has returned to its idle state. The user must write the bus mode
// register on cfg_ only while no request is in progress; the block itself does
// not enforce it.
`default_nettype none

`include "assert_macros.svh"

module char_lcd_interface_sequencer_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,      // bus_width_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[2:0], value[10:3], line[12:11], column[18:13], glyph_slot[21:19]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // enable[0], data_bus[8:1], hold_ms[14:9]
    output logic [15:0]      m_tdata,
    output logic             m_tuser,       // register_select
    output logic             m_tlast
);

    import lcdseq_pkg::*;

    logic       mode_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    lcdseq_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .bus_width_mode (mode_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .cmd            (cmd),
        .status         (status)
    );

    lcdseq_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .bus_width_mode (mode_reg),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

    // a new request is only taken once the datapath has finished
    `ASSERT_IMPLIES(a_ready_dp_idle, clk, rst_n, s_tready, status.idle)
    // whatever waits at the output when idle closes the previous request
    `ASSERT_IMPLIES(a_idle_out_last, clk, rst_n, s_tready && m_tvalid, m_tlast)
    // an accepted init request loads the datapath in the next cycle
    `ASSERT_NEXT(a_accept_load, clk, rst_n,
                 s_tvalid && s_tready && (s_tdata[2:0] == OP_INIT), cmd.load)

endmodule

`default_nettype wire

// ===== hdl/lcdseq_ctrl.sv =====
`default_nettype none

module lcdseq_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   bus_width_mode,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,
    output lcdseq_pkg::dp_cmd_t         cmd,
    input  wire lcdseq_pkg::dp_status_t status
);

    import lcdseq_pkg::*;

    typedef enum logic
    {
        IDLE,
        RUN
    } state_t;

    state_t     state_reg;
    logic [2:0] idx_reg;
    dp_cmd_t    cmd_reg;

    opcode_t    op;
    logic [7:0] value;
    logic [1:0] line;
    logic [5:0] column;
    logic [2:0] slot;
    logic [7:0] pos_byte;
    logic [7:0] glyph_byte;

    always_comb
    begin
        op         = opcode_t'(s_tdata[2:0]);
        value      = s_tdata[10:3];
        line       = s_tdata[12:11];
        column     = s_tdata[18:13];
        slot       = s_tdata[21:19];
        pos_byte   = (line[0] ? DDRAM_LINE1 : DDRAM_LINE0) + {2'b00, column};
        glyph_byte = CGRAM_BASE + {2'b00, slot, 3'b000};
    end

    assign s_tready = (state_reg == IDLE);
    assign cmd      = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            idx_reg   <= INIT_DONE_IDX;
            cmd_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        unique case (op)
                            OP_WR_CMD, OP_WR_DATA:
                            begin
                                cmd_reg   <= '{load: 1'b1, wait_state: 1'b0,
                                               rs: (op == OP_WR_DATA), data: value,
                                               extra: EXTRA_NONE, final_xfer: 1'b1};
                                idx_reg   <= INIT_DONE_IDX;
                                state_reg <= RUN;
                            end
                            OP_INIT:
                            begin
                                cmd_reg   <= '{load: 1'b1, wait_state: 1'b1, rs: 1'b0,
                                               data: 8'h00, extra: EXTRA_NONE,
                                               final_xfer: 1'b0};
                                idx_reg   <= bus_width_mode ? INIT_FIRST_4BIT
                                                            : INIT_FIRST_8BIT;
                                state_reg <= RUN;
                            end
                            OP_SET_POS:
                            begin
                                // lines 2 and 3 are dropped without output
                                if (line[1] == 1'b0)
                                begin
                                    cmd_reg   <= '{load: 1'b1, wait_state: 1'b0, rs: 1'b0,
                                                   data: pos_byte, extra: EXTRA_NONE,
                                                   final_xfer: 1'b1};
                                    idx_reg   <= INIT_DONE_IDX;
                                    state_reg <= RUN;
                                end
                            end
                            OP_SET_GLYPH:
                            begin
                                cmd_reg   <= '{load: 1'b1, wait_state: 1'b0, rs: 1'b0,
                                               data: glyph_byte, extra: EXTRA_NONE,
                                               final_xfer: 1'b1};
                                idx_reg   <= INIT_DONE_IDX;
                                state_reg <= RUN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                RUN:
                begin
                    if (cmd_reg.load)
                    begin
                        cmd_reg.load <= 1'b0;
                    end
                    // datapath idle and no load in flight: transfer finished
                    else if (status.idle)
                    begin
                        if (idx_reg == INIT_DONE_IDX)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            cmd_reg <= '{load: 1'b1, wait_state: 1'b0, rs: 1'b0,
                                         data: init_cmd(idx_reg, bus_width_mode),
                                         extra: (idx_reg == INIT_CLEAR_IDX) ? EXTRA_CLEAR
                                                                            : EXTRA_SHORT,
                                         final_xfer: (idx_reg == INIT_LAST_IDX)};
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcdseq_dp.sv =====
`default_nettype none

module lcdseq_dp
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  bus_width_mode,
    input  wire lcdseq_pkg::dp_cmd_t   cmd,
    output lcdseq_pkg::dp_status_t     status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    import lcdseq_pkg::*;

    logic       active_reg;
    logic [1:0] phase_reg;
    logic       wait_reg;
    logic       rs_reg;
    logic [7:0] byte_reg;
    logic [1:0] extra_reg;
    logic       final_reg;
    logic [7:0] held_bus_reg;
    logic       held_select_reg;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    logic       out_free;
    logic       emit;
    logic       st_rs;
    logic       st_en;
    logic [7:0] st_bus;
    logic [5:0] st_hold;
    logic       st_final;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = active_reg && out_free;

    // pin state for the current phase: even phases raise enable, odd lower it; the power-up wait holds enable low
    always_comb
    begin
        if (wait_reg)
        begin
            st_rs    = held_select_reg;
            st_en    = 1'b0;
            st_bus   = held_bus_reg;
            st_hold  = POWER_UP_WAIT_MS;
            st_final = 1'b1;
        end
        else
        begin
            st_rs = rs_reg;
            st_en = !phase_reg[0];
            if (bus_width_mode)
            begin
                st_bus   = {4'h0, phase_reg[1] ? byte_reg[3:0] : byte_reg[7:4]};
                st_final = (phase_reg == 2'd3);
            end
            else
            begin
                st_bus   = byte_reg;
                st_final = phase_reg[0];
            end
            st_hold = st_final ? 6'd1 + {4'b0000, extra_reg} : 6'd1;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            phase_reg       <= 2'd0;
            held_bus_reg    <= 8'h00;
            held_select_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.load)
            begin
                active_reg <= 1'b1;
                phase_reg  <= 2'd0;
            end
            else if (emit)
            begin
                held_bus_reg    <= st_bus;
                held_select_reg <= st_rs;
                phase_reg       <= phase_reg + 2'd1;
                if (st_final)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wait_reg  <= cmd.wait_state;
            rs_reg    <= cmd.rs;
            byte_reg  <= cmd.data;
            extra_reg <= cmd.extra;
            final_reg <= cmd.final_xfer;
        end
        if (emit)
        begin
            m_tdata_reg <= {1'b0, st_hold, st_bus, st_en};
            m_tuser_reg <= st_rs;
            m_tlast_reg <= st_final && final_reg;
        end
    end

    assign status.idle = !active_reg;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign m_tuser     = m_tuser_reg;
    assign m_tlast     = m_tlast_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_char_lcd_interface_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_char_lcd_interface_sequencer_core;
    import lcdseq_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int IDLE_SETTLE      = 64;
    localparam int RAND_PHASE_ITEMS = 85;

    // opcodes the block does not define
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed
    {
        logic       rs;
        logic       en;
        logic [7:0] bus;
        logic [5:0] hold;
        logic       last;
    } pin_t;

    typedef struct packed
    {
        logic       mode;
        logic [2:0] op;
        logic [7:0] value;
        logic [1:0] line;
        logic [5:0] column;
        logic [2:0] slot;
        logic       typed;
        logic [4:0] n_pins;
        pin_t       first;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // predictor state
    logic       bus_mode = 1'b0;
    logic [7:0] held_bus = 8'h00;
    logic       held_rs  = 1'b0;

    pin_t pending_pins[$];
    row_t directed[$];
    int   errors     = 0;
    int   cycles     = 0;
    int   burst_left = 0;

    char_lcd_interface_sequencer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic put_pin(input logic rs, input logic en, input logic [7:0] bus,
                           input logic [5:0] hold);
        pin_t p;
        p.rs   = rs;
        p.en   = en;
        p.bus  = bus;
        p.hold = hold;
        p.last = 1'b0;
        pending_pins.push_back(p);
        held_bus = bus;
        held_rs  = rs;
    endtask

    task automatic send_byte(input logic rs, input logic [7:0] b, input logic [1:0] extra);
        if (bus_mode)
        begin
            put_pin(rs, 1'b1, {4'h0, b[7:4]}, 6'd1);
            put_pin(rs, 1'b0, {4'h0, b[7:4]}, 6'd1);
            put_pin(rs, 1'b1, {4'h0, b[3:0]}, 6'd1);
            put_pin(rs, 1'b0, {4'h0, b[3:0]}, 6'd1 + {4'b0000, extra});
        end
        else
        begin
            put_pin(rs, 1'b1, b, 6'd1);
            put_pin(rs, 1'b0, b, 6'd1 + {4'b0000, extra});
        end
    endtask

    // appends the pin states one request produces; count is how many
    task automatic plan_pin_states(input logic [23:0] req, output int count);
        int         start_n;
        logic [2:0] op;
        logic [7:0] value;
        logic [1:0] line;
        logic [5:0] column;
        logic [2:0] slot;
        pin_t       p;
        start_n = pending_pins.size();
        op      = req[2:0];
        value   = req[10:3];
        line    = req[12:11];
        column  = req[18:13];
        slot    = req[21:19];
        case (op)
            OP_WR_CMD:
                send_byte(1'b0, value, EXTRA_NONE);
            OP_WR_DATA:
                send_byte(1'b1, value, EXTRA_NONE);
            OP_INIT:
            begin
                put_pin(held_rs, 1'b0, held_bus, POWER_UP_WAIT_MS);
                if (bus_mode)
                begin
                    send_byte(1'b0, CMD_HOME, EXTRA_SHORT);
                    send_byte(1'b0, CMD_FUNC_4BIT, EXTRA_SHORT);
                end
                else
                begin
                    send_byte(1'b0, CMD_FUNC_8BIT, EXTRA_SHORT);
                end
                send_byte(1'b0, CMD_DISPLAY_ON, EXTRA_SHORT);
                send_byte(1'b0, CMD_CLEAR, EXTRA_CLEAR);
                send_byte(1'b0, CMD_ENTRY_MODE, EXTRA_SHORT);
            end
            OP_SET_POS:
            begin
                // lines 2 and 3 are dropped silently
                if (line == 2'd0)
                    send_byte(1'b0, DDRAM_LINE0 + {2'b00, column}, EXTRA_NONE);
                else if (line == 2'd1)
                    send_byte(1'b0, DDRAM_LINE1 + {2'b00, column}, EXTRA_NONE);
            end
            OP_SET_GLYPH:
                send_byte(1'b0, CGRAM_BASE + {2'b00, slot, 3'b000}, EXTRA_NONE);
            default:
            begin
            end
        endcase
        count = pending_pins.size() - start_n;
        if (count > 0)
        begin
            p = pending_pins[pending_pins.size() - 1];
            p.last = 1'b1;
            pending_pins[pending_pins.size() - 1] = p;
        end
    endtask

    task automatic send_request(input logic [23:0] req, input logic typed,
                                input logic [4:0] n_typed, input pin_t first);
        int   n;
        pin_t p;
        s_tdata  <= req;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        plan_pin_states(req, n);
        if (typed)
        begin
            if (n != n_typed)
                note_error($sformatf("request %06h: %0d pin states listed, %0d predicted",
                                     req, n_typed, n));
            // listed first state stands in for the predicted one
            if (n > 0)
            begin
                p      = first;
                p.last = (n == 1);
                pending_pins[pending_pins.size() - n] = p;
            end
        end
    endtask

    task automatic drain_pending();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pins.size() != 0)
            @(posedge clk);
    endtask

    // dropped requests may still be in flight, hence the settle before the write
    task automatic write_mode(input logic v);
        drain_pending();
        repeat (IDLE_SETTLE) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        bus_mode = v;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic add_row(input logic mode, input logic [2:0] op, input logic [7:0] value,
                           input logic [1:0] line, input logic [5:0] column,
                           input logic [2:0] slot, input logic typed, input logic [4:0] n,
                           input logic rs, input logic en, input logic [7:0] bus,
                           input logic [5:0] hold);
        row_t r;
        r.mode       = mode;
        r.op         = op;
        r.value      = value;
        r.line       = line;
        r.column     = column;
        r.slot       = slot;
        r.typed      = typed;
        r.n_pins     = n;
        r.first.rs   = rs;
        r.first.en   = en;
        r.first.bus  = bus;
        r.first.hold = hold;
        r.first.last = 1'b0;
        directed.push_back(r);
    endtask

    // receiver: stretches of always-ready, coin-flip and periodic stalls
    initial
    begin : rx_side
        int style;
        int stretch;
        int period;
        int phase;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            style   = $urandom_range(0, 2);
            stretch = $urandom_range(16, 160);
            period  = $urandom_range(2, 8);
            phase   = 0;
            repeat (stretch)
            begin
                @(posedge clk);
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (phase == 0);
                endcase
                phase = (phase + 1) % period;
            end
        end
    end

    always @(posedge clk)
    begin : pin_check
        pin_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pins.size() == 0)
            begin
                note_error($sformatf("unexpected pin state: tdata=%04h rs=%0b last=%0b",
                                     m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                want = pending_pins.pop_front();
                if (m_tuser !== want.rs || m_tdata[0] !== want.en
                    || m_tdata[8:1] !== want.bus || m_tdata[14:9] !== want.hold
                    || m_tlast !== want.last)
                    note_error($sformatf({"pin state mismatch: expected rs=%0b en=%0b bus=%02h ",
                                          "hold=%0d last=%0b, got rs=%0b en=%0b bus=%02h ",
                                          "hold=%0d last=%0b"},
                                         want.rs, want.en, want.bus, want.hold, want.last,
                                         m_tuser, m_tdata[0], m_tdata[8:1], m_tdata[14:9],
                                         m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[char_lcd_interface_sequencer_core] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          k;
        int          hold_at;
        int          r;
        logic [2:0]  op;
        logic [1:0]  line;
        logic [23:0] req;
        pin_t        blank;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        blank     = '0;

        // 8-bit bus
        add_row(0, OP_WR_CMD,    8'h00, 0, 0,  0, 1, 2,  0, 1, 8'h00, 1);
        add_row(0, OP_WR_DATA,   8'hFF, 3, 63, 7, 1, 2,  1, 1, 8'hFF, 1);
        add_row(0, OP_INIT,      8'h00, 0, 0,  0, 1, 9,  1, 0, 8'hFF, 50);
        add_row(0, OP_SET_POS,   8'hFF, 0, 0,  7, 1, 2,  0, 1, 8'h80, 1);
        add_row(0, OP_SET_POS,   8'h00, 1, 63, 0, 1, 2,  0, 1, 8'hFF, 1);
        add_row(0, OP_SET_POS,   8'h00, 2, 21, 0, 1, 0,  0, 0, 8'h00, 0);
        add_row(0, OP_SET_POS,   8'hFF, 3, 63, 7, 1, 0,  0, 0, 8'h00, 0);
        add_row(0, OP_SET_GLYPH, 8'hFF, 3, 63, 7, 1, 2,  0, 1, 8'h78, 1);
        add_row(0, OP_SPARE_HI,  8'hFF, 3, 63, 7, 1, 0,  0, 0, 8'h00, 0);
        add_row(0, OP_WR_DATA,   8'h5A, 1, 12, 3, 0, 0,  0, 0, 8'h00, 0);
        // nibble transfers
        add_row(1, OP_WR_CMD,    8'hA5, 0, 0,  0, 1, 4,  0, 1, 8'h0A, 1);
        add_row(1, OP_INIT,      8'hFF, 3, 63, 7, 1, 21, 0, 0, 8'h05, 50);
        add_row(1, OP_INIT,      8'h00, 0, 0,  0, 1, 21, 0, 0, 8'h06, 50);
        add_row(1, OP_WR_DATA,   8'h00, 2, 40, 5, 1, 4,  1, 1, 8'h00, 1);
        add_row(1, OP_SET_GLYPH, 8'h00, 0, 0,  0, 1, 4,  0, 1, 8'h04, 1);
        add_row(1, OP_SET_POS,   8'h00, 1, 0,  0, 1, 4,  0, 1, 8'h0C, 1);
        add_row(1, OP_SET_POS,   8'h00, 0, 63, 0, 1, 4,  0, 1, 8'h0B, 1);
        add_row(1, OP_SPARE_LO,  8'h00, 0, 0,  0, 1, 0,  0, 0, 8'h00, 0);
        add_row(1, OP_SPARE_MID, 8'hAA, 2, 42, 5, 1, 0,  0, 0, 8'h00, 0);
        add_row(1, OP_SET_POS,   8'h00, 3, 0,  0, 0, 0,  0, 0, 8'h00, 0);
        add_row(1, OP_WR_DATA,   8'hC3, 0, 0,  0, 0, 0,  0, 0, 8'h00, 0);
        // back to 8-bit, init picks up the last nibble state
        add_row(0, OP_INIT,      8'h00, 0, 0,  0, 1, 9,  1, 0, 8'h03, 50);
        add_row(0, OP_WR_CMD,    8'h01, 0, 0,  0, 0, 0,  0, 0, 8'h00, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (i == 0 || directed[i].mode !== bus_mode)
                write_mode(directed[i].mode);
            pace_sender();
            send_request({2'b00, directed[i].slot, directed[i].column, directed[i].line,
                          directed[i].value, directed[i].op},
                         directed[i].typed, directed[i].n_pins, directed[i].first);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            write_mode(ph % 2 == 0);
            hold_at = $urandom_range(10, RAND_PHASE_ITEMS - 10);
            for (k = 0; k < RAND_PHASE_ITEMS; k++)
            begin
                if (k == hold_at)
                    drain_pending();
                pace_sender();
                r = $urandom_range(0, 99);
                if (r < 30)
                    op = OP_WR_DATA;
                else if (r < 50)
                    op = OP_WR_CMD;
                else if (r < 56)
                    op = OP_INIT;
                else if (r < 78)
                    op = OP_SET_POS;
                else if (r < 92)
                    op = OP_SET_GLYPH;
                else
                    op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                // positions mostly on the two real lines
                if (op == OP_SET_POS && $urandom_range(0, 99) < 85)
                    line = 2'($urandom_range(0, 1));
                else
                    line = 2'($urandom_range(0, 3));
                req          = 24'($urandom);
                req[2:0]     = op;
                req[12:11]   = line;
                req[23:22]   = 2'b00;
                send_request(req, 1'b0, 5'd0, blank);
            end
        end

        drain_pending();
        repeat (IDLE_SETTLE) @(posedge clk);
        if (errors == 0)
            $display("[char_lcd_interface_sequencer_core] OK");
        else
            $display("[char_lcd_interface_sequencer_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lcdseq_pkg.sv
hdl/lcdseq_ctrl.sv
hdl/lcdseq_dp.sv
hdl/char_lcd_interface_sequencer_core.sv
tb/sv/tb_char_lcd_interface_sequencer_core.sv
